// File: rtl/csr_sparse_matrix_vector_multiply_macros.svh
// Assertion macros shared by the RTL of the CSR sparse matrix-vector block.
// Expects i_clk and i_rst_n in the scope of each use; no other dependencies.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSRMV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csrmv: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CSRMV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csrmv: next-cycle check failed");

`endif

// File: rtl/csrmv_pkg.sv
// Shared widths, defaults and request codes for the CSR sparse matrix-vector block.
// No dependencies; imported by every module of the block.
package csrmv_pkg;

    localparam int REQ_W  = 2;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int ROW_W  = 16;

    localparam int              VECTOR_DEPTH_DEF = 1024;
    localparam longint unsigned MAX_ROWS_DEF     = 64'd65536;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_EMPTY = 2'd2
    } t_req;

endpackage

// File: rtl/csr_sparse_matrix_vector_multiply.sv
// CSR sparse matrix times dense vector. One beat is taken every cycle; o_busy is high
// during reset and until the ready register sets after it, then stays low. A row
// result strobes o_result_valid for one cycle once the beat that ends the row has
// passed store read, term register, then accumulate. The receiver cannot stall results.
// Synchronous active-low reset clears the mode, accumulator, row counter and pipeline;
// the vector store is not cleared and holds garbage until loaded.
module csr_sparse_matrix_vector_multiply #(
    parameter int              VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter longint unsigned MAX_ROWS     = csrmv_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request beat
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [csrmv_pkg::REQ_W-1:0]    i_req_type,
    input  logic [csrmv_pkg::IDX_W-1:0]    i_vector_index,
    input  logic signed [csrmv_pkg::DATA_W-1:0] i_vector_value,
    input  logic [csrmv_pkg::IDX_W-1:0]    i_column_position,
    input  logic signed [csrmv_pkg::DATA_W-1:0] i_matrix_value,
    input  logic                           i_row_end,
    // mode register write
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    // row result beat
    output logic                           o_result_valid,
    output logic [csrmv_pkg::ROW_W-1:0]    o_row_number,
    output logic signed [csrmv_pkg::DATA_W-1:0] o_row_sum
);
    import csrmv_pkg::*;

    `include "csr_sparse_matrix_vector_multiply_macros.svh"

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    // Control that rides along each pipeline stage.
    typedef struct packed {
        logic valid;
        t_req req;
        logic last;
    } t_stage_ctl;

    // ------------------------------------------------------------------
    // Accept and mode register
    // ------------------------------------------------------------------
    logic r_ready;
    logic r_bool_mode;
    logic accept;

    // Come up ready in the cycle after reset; the pipeline never stalls after that.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_bool_mode <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_wr_en) begin
                r_bool_mode <= i_cfg_wr_data;
            end
        end
    end

    assign o_busy = ~r_ready;
    assign accept = i_start & r_ready;

    // ------------------------------------------------------------------
    // Stage 0: store write for loads, store read for nonzeros.
    // A load writes at its accept edge, so a nonzero one beat later already
    // reads the new value: no forwarding path is needed.
    // ------------------------------------------------------------------
    t_req        in_req;
    logic        idx_ok;
    logic        col_ok;
    logic        st_wr_en;
    logic        st_rd_en;
    logic [DATA_W-1:0] st_rd_data;

    assign in_req   = t_req'(i_req_type);
    assign idx_ok   = 32'(i_vector_index) < 32'(VECTOR_DEPTH);
    assign col_ok   = 32'(i_column_position) < 32'(VECTOR_DEPTH);
    assign st_wr_en = accept && (in_req == REQ_LOAD) && idx_ok;
    assign st_rd_en = accept && (in_req == REQ_ENTRY) && col_ok;

    csrmv_vec_store #(
        .DEPTH (VECTOR_DEPTH),
        .AW    (AW)
    ) u_vec_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (AW'(i_vector_index)),
        .i_wr_data (i_vector_value),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (AW'(i_column_position)),
        .o_rd_data (st_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: element arrives from the store; form the term.
    // ------------------------------------------------------------------
    t_stage_ctl        r_s1;
    logic [DATA_W-1:0] r_s1_mval;
    logic              r_s1_col_ok;

    // Only the valid bit is reset; the rest rides along unqualified.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= accept;
        end
        r_s1.req    <= in_req;
        r_s1.last   <= i_row_end;
        r_s1_mval   <= i_matrix_value;
        r_s1_col_ok <= col_ok;
    end

    logic [DATA_W-1:0] elem;
    logic [DATA_W-1:0] term;

    // Out-of-range columns read as zero.
    assign elem = r_s1_col_ok ? st_rd_data : '0;
    assign term = r_bool_mode ? (r_s1_mval & elem) : DATA_W'(r_s1_mval * elem);

    // ------------------------------------------------------------------
    // Stage 2: accumulate, close rows, clear on loads.
    // ------------------------------------------------------------------
    t_stage_ctl        r_s2;
    logic [DATA_W-1:0] r_s2_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1.valid;
        end
        r_s2.req  <= r_s1.req;
        r_s2.last <= r_s1.last;
        r_s2_term <= term;
    end

    logic [DATA_W-1:0] r_acc,       n_acc;
    logic [ROW_W-1:0]  r_row_cnt,   n_row_cnt;
    logic              r_out_valid, n_out_valid;
    logic [ROW_W-1:0]  r_out_row,   n_out_row;
    logic [DATA_W-1:0] r_out_sum,   n_out_sum;

    logic [DATA_W-1:0] acc_sum;
    logic [ROW_W:0]    cnt_inc;
    logic              cnt_wrap;
    logic [ROW_W-1:0]  cnt_next;
    logic              s2_closes;

    assign acc_sum  = r_bool_mode ? (r_acc ^ r_s2_term) : (r_acc + r_s2_term);
    assign cnt_inc  = (ROW_W + 1)'(r_row_cnt) + (ROW_W + 1)'(1);
    // Wrap at MAX_ROWS, and in any case at the counter width.
    assign cnt_wrap = (64'(cnt_inc) >= MAX_ROWS) || cnt_inc[ROW_W];
    assign cnt_next = cnt_wrap ? '0 : cnt_inc[ROW_W-1:0];

    // Stage 2 holds a beat that ends a row.
    assign s2_closes = r_s2.valid &&
                       ((r_s2.req == REQ_EMPTY) || ((r_s2.req == REQ_ENTRY) && r_s2.last));

    always_comb begin
        n_acc       = r_acc;
        n_row_cnt   = r_row_cnt;
        n_out_valid = 1'b0;
        n_out_row   = r_out_row;
        n_out_sum   = r_out_sum;
        if (r_s2.valid) begin
            unique case (r_s2.req)
                REQ_LOAD: begin
                    n_acc     = '0;
                    n_row_cnt = '0;
                end
                REQ_ENTRY: begin
                    if (r_s2.last) begin
                        // close the row with this term folded in
                        n_out_valid = 1'b1;
                        n_out_row   = r_row_cnt;
                        n_out_sum   = acc_sum;
                        n_acc       = '0;
                        n_row_cnt   = cnt_next;
                    end else begin
                        n_acc = acc_sum;
                    end
                end
                REQ_EMPTY: begin
                    // emit whatever is pending, then start clean
                    n_out_valid = 1'b1;
                    n_out_row   = r_row_cnt;
                    n_out_sum   = r_acc;
                    n_acc       = '0;
                    n_row_cnt   = cnt_next;
                end
                default: begin
                    // unused request code: drop it
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_row_cnt   <= n_row_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset; the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        r_out_row <= n_out_row;
        r_out_sum <= n_out_sum;
    end

    assign o_result_valid = r_out_valid;
    assign o_row_number   = r_out_row;
    assign o_row_sum      = r_out_sum;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `CSRMV_ASSERT_NOW(a_strobe_has_source, r_out_valid, $past(s2_closes))
    `CSRMV_ASSERT_NEXT(a_load_clears, r_s2.valid && r_s2.req == REQ_LOAD, r_acc == '0 && r_row_cnt == '0)
    `CSRMV_ASSERT_NEXT(a_cnt_holds, !r_s2.valid, $stable(r_row_cnt) && $stable(r_acc))
    `CSRMV_ASSERT_NEXT(a_row_close_clears, n_out_valid, r_acc == '0)

endmodule

// File: rtl/csrmv_vec_store.sv
// Dense vector store: one write port, one read port, registered read data.
// Depends on csrmv_pkg for the data width and the default depth.
module csrmv_vec_store #(
    parameter int DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
    parameter int AW    = $clog2(csrmv_pkg::VECTOR_DEPTH_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [csrmv_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [csrmv_pkg::DATA_W-1:0] o_rd_data
);
    import csrmv_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/csr_spmv_row_checker.sv
// Row-result checker for the CSR sparse matrix-vector block: it tracks the dense vector,
// the row accumulator and the row counter, and compares every row result with its prediction.
// Depends on csrmv_pkg for widths, depth, row limit and request codes.
module csr_spmv_row_checker
    import csrmv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [IDX_W-1:0]         i_vector_index,
    input  logic [DATA_W-1:0]        i_vector_value,
    input  logic [IDX_W-1:0]         i_column_position,
    input  logic [DATA_W-1:0]        i_matrix_value,
    input  logic                     i_row_end,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,
    input  logic                     i_result_valid,
    input  logic [ROW_W-1:0]         i_row_number,
    input  logic [DATA_W-1:0]        i_row_sum,
    output int                       o_mismatch_count,
    output int                       o_outstanding
);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] sum;
    } t_row_result;

    t_row_result       expected_rows[$];
    logic [DATA_W-1:0] dense_vector[VECTOR_DEPTH_DEF];
    logic [DATA_W-1:0] row_acc;
    logic [ROW_W-1:0]  row_idx;
    logic              xor_mode;

    // Emit the running row, clear the sum, advance the row index with its wrap.
    function automatic void close_row();
        longint unsigned nxt;
        t_row_result     done_row;
        done_row.row = row_idx;
        done_row.sum = row_acc;
        expected_rows.insert(expected_rows.size(), done_row);
        row_acc = '0;
        nxt = longint'(row_idx) + 1;
        row_idx = (nxt >= MAX_ROWS_DEF) ? '0 : ROW_W'(nxt);
    endfunction

    function automatic void fold_beat();
        logic [DATA_W-1:0] elem;
        case (i_req_type)
            REQ_LOAD: begin
                dense_vector[i_vector_index] = i_vector_value;
                row_acc = '0;
                row_idx = '0;
            end
            REQ_ENTRY: begin
                elem = dense_vector[i_column_position];
                if (xor_mode) begin
                    row_acc = row_acc ^ (i_matrix_value & elem);
                end else begin
                    row_acc = row_acc + i_matrix_value * elem;
                end
                if (i_row_end) begin
                    close_row();
                end
            end
            REQ_EMPTY: begin
                close_row();
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            expected_rows.delete();
            row_acc = '0;
            row_idx = '0;
            xor_mode = 1'b0;
            o_mismatch_count = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row result: row_number %0d row_sum 0x%h",
                           i_row_number, i_row_sum);
                    o_mismatch_count++;
                end else begin
                    want = expected_rows.pop_front();
                    if (i_row_number !== want.row) begin
                        $error("row_number: expected %0d, got %0d", want.row, i_row_number);
                        o_mismatch_count++;
                    end
                    if (i_row_sum !== want.sum) begin
                        $error("row_sum: expected 0x%h, got 0x%h", want.sum, i_row_sum);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                xor_mode = i_cfg_wr_data;
            end
            if (i_start && !i_busy) begin
                fold_beat();
            end
        end
        o_outstanding <= expected_rows.size();
    end

endmodule

// File: verif/tb_csr_sparse_matrix_vector_multiply.sv
// Top of the testbench for csr_sparse_matrix_vector_multiply: clock, reset, request beats,
// mode writes, stall watchdog and verdict. Depends on csrmv_pkg and csr_spmv_row_checker.
module tb_csr_sparse_matrix_vector_multiply;
    import csrmv_pkg::*;

    localparam int DEPTH         = VECTOR_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 1200;
    // Results trail their beats through the pipeline; give the pipeline room before a mode
    // write and before the verdict.
    localparam int SETTLE_CYCLES = 8;
    // Longest legal quiet stretch: the longest sender gap or a drain plus settle.
    // Take that many times over.
    localparam int STALL_LIMIT   = 1000;
    // Length of the back-to-back burst of empty rows.
    localparam int BURST_ROWS    = 40;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [REQ_W-1:0]         i_req_type;
    logic [IDX_W-1:0]         i_vector_index;
    logic signed [DATA_W-1:0] i_vector_value;
    logic [IDX_W-1:0]         i_column_position;
    logic signed [DATA_W-1:0] i_matrix_value;
    logic                     i_row_end;
    logic                     i_cfg_wr_en;
    logic                     i_cfg_wr_data;
    logic                     o_result_valid;
    logic [ROW_W-1:0]         o_row_number;
    logic signed [DATA_W-1:0] o_row_sum;

    int mismatch_count;
    int outstanding;
    int stall_cycles;
    int beats_sent;
    bit no_gaps;

    // Track which vector entries hold data; entries only read from this list.
    bit loaded[DEPTH];
    int loaded_cols[$];

    csr_sparse_matrix_vector_multiply DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_req_type        (i_req_type),
        .i_vector_index    (i_vector_index),
        .i_vector_value    (i_vector_value),
        .i_column_position (i_column_position),
        .i_matrix_value    (i_matrix_value),
        .i_row_end         (i_row_end),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_result_valid    (o_result_valid),
        .o_row_number      (o_row_number),
        .o_row_sum         (o_row_sum)
    );

    csr_spmv_row_checker row_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_req_type        (i_req_type),
        .i_vector_index    (i_vector_index),
        .i_vector_value    (i_vector_value),
        .i_column_position (i_column_position),
        .i_matrix_value    (i_matrix_value),
        .i_row_end         (i_row_end),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_result_valid    (o_result_valid),
        .i_row_number      (o_row_number),
        .i_row_sum         (o_row_sum),
        .o_mismatch_count  (mismatch_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bias values toward the signed extremes, zero and all ones.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return '0;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return IDX_W'($urandom_range(0, DEPTH - 1));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_col();
        return IDX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Hold the beat until the block takes it, then maybe idle with junk on the fields.
    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] vidx,
                             input logic [DATA_W-1:0] vval, input logic [IDX_W-1:0] col,
                             input logic [DATA_W-1:0] mval, input logic last);
        int g;
        i_start           <= 1'b1;
        i_req_type        <= req;
        i_vector_index    <= vidx;
        i_vector_value    <= vval;
        i_column_position <= col;
        i_matrix_value    <= mval;
        i_row_end         <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (req != REQ_UNUSED) beats_sent++;
        if (req == REQ_LOAD && !loaded[vidx]) begin
            loaded[vidx] = 1'b1;
            loaded_cols.insert(loaded_cols.size(), int'(vidx));
        end
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            i_start           <= 1'b0;
            i_req_type        <= REQ_W'($urandom);
            i_vector_index    <= IDX_W'($urandom);
            i_vector_value    <= $urandom;
            i_column_position <= IDX_W'($urandom);
            i_matrix_value    <= $urandom;
            i_row_end         <= 1'($urandom);
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic load_elem(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        send_beat(REQ_LOAD, idx, val, IDX_W'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic add_entry(input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] mval,
                             input logic last);
        send_beat(REQ_ENTRY, IDX_W'($urandom), $urandom, col, mval, last);
    endtask

    task automatic empty_row();
        send_beat(REQ_EMPTY, IDX_W'($urandom), $urandom, IDX_W'($urandom), $urandom,
                  1'($urandom));
    endtask

    task automatic junk_beat();
        send_beat(REQ_UNUSED, IDX_W'($urandom), $urandom, IDX_W'($urandom), $urandom,
                  1'($urandom));
    endtask

    // Drain all pending rows, let the pipeline settle, then write the mode bit.
    task automatic set_mode(input logic xor_acc);
        i_start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= xor_acc;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'($urandom);
    endtask

    // Drop the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int random_base;
        int nnz;
        int r;
        i_rst_n           <= 1'b0;
        i_start           <= 1'b0;
        i_req_type        <= '0;
        i_vector_index    <= '0;
        i_vector_value    <= '0;
        i_column_position <= '0;
        i_matrix_value    <= '0;
        i_row_end         <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= 1'b0;
        beats_sent = 0;
        no_gaps    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: integer mode, extremes of every field, each request code.
        set_mode(1'b0);
        load_elem('0, 32'h7FFF_FFFF);
        load_elem('1, 32'h8000_0000);
        load_elem(10'h155, 32'hFFFF_FFFF);
        load_elem(10'h2AA, 32'h0000_0001);
        load_elem(10'd5, '0);
        junk_beat();
        add_entry('0, 32'h7FFF_FFFF, 1'b0);
        add_entry('1, 32'h8000_0000, 1'b0);
        add_entry(10'h155, 32'hFFFF_FFFF, 1'b1);
        empty_row();
        // Empty row arriving with a sum still open: it flushes that sum.
        add_entry(10'h2AA, 32'h8000_0000, 1'b0);
        empty_row();
        add_entry(10'd5, '0, 1'b1);
        junk_beat();
        add_entry('1, 32'hFFFF_FFFF, 1'b1);
        // A load in the middle of a row drops the partial sum and rewinds the row count.
        add_entry('0, 32'h1234_5678, 1'b0);
        load_elem(10'd7, 32'hDEAD_BEEF);
        add_entry(10'd7, 32'h0000_0003, 1'b1);

        // Directed: boolean mode over the same extremes.
        set_mode(1'b1);
        add_entry('0, 32'hFFFF_FFFF, 1'b0);
        add_entry('1, 32'hFFFF_0000, 1'b0);
        add_entry(10'h155, 32'h0F0F_0F0F, 1'b1);
        empty_row();

        // Run a burst of empty rows back to back.
        set_mode(1'b0);
        no_gaps = 1'b1;
        load_elem(10'h3C3, rand_word());
        repeat (BURST_ROWS) empty_row();
        add_entry(10'h3C3, rand_word(), 1'b1);
        no_gaps = 1'b0;

        // Random: phases of loads followed by well-formed rows, with some noise
        // and broken rows mixed in. Each phase picks a fresh mode.
        random_base = beats_sent;
        while (beats_sent - random_base < RANDOM_ITEMS) begin
            set_mode(1'($urandom_range(0, 1)));
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 6)) load_elem(rand_index(), rand_word());
            repeat ($urandom_range(2, 12)) begin
                nnz = $urandom_range(0, 5);
                if (nnz == 0) begin
                    empty_row();
                end else begin
                    for (int k = 0; k < nnz; k++) begin
                        if ($urandom_range(0, 29) == 0) junk_beat();
                        add_entry(pick_col(), rand_word(), k == nnz - 1);
                    end
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    add_entry(pick_col(), rand_word(), 1'b0);
                    empty_row();
                end else if (r < 7) begin
                    add_entry(pick_col(), rand_word(), 1'b0);
                    load_elem(rand_index(), rand_word());
                end
            end
        end

        // Drain, let the pipeline go quiet, then give the verdict.
        i_start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
